// ===== rtl/wav_riff_header_parser_top_defines.svh =====
// Assertion macros shared by the RIFF/WAVE header parser RTL.
`ifndef WAV_RIFF_HEADER_PARSER_TOP_DEFINES_SVH
`define WAV_RIFF_HEADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define WRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wrp assertion failed");

// Next-cycle implication, checked outside of reset.
`define WRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wrp assertion failed");

`endif

// ===== rtl/wrp_pkg.sv =====
// Shared types, constants and functions of the RIFF/WAVE header parser.
`default_nettype none

package wrp_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_FALLBACK_RATE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CHUNK_LIMIT   = 2'd1;

    localparam logic [31:0] FALLBACK_RATE_RESET = 32'd32000;
    localparam logic [7:0]  CHUNK_LIMIT_RESET   = 8'd20;

    localparam logic [2:0] PH_DONE = 3'd0;
    localparam logic [2:0] PH_RIFF = 3'd1;
    localparam logic [2:0] PH_HDR  = 3'd2;
    localparam logic [2:0] PH_FMT  = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;

    localparam logic [3:0] MAGIC_SIZE_FIRST = 4'd4;
    localparam logic [3:0] MAGIC_WAVE_FIRST = 4'd8;
    localparam logic [3:0] MAGIC_LAST       = 4'd11;
    localparam logic [3:0] MAGIC_LEN        = 4'd12;
    localparam logic [3:0] HDR_SIZE_FIRST   = 4'd4;
    localparam logic [3:0] HDR_LAST         = 4'd7;
    localparam logic [3:0] FMT_RATE_FIRST   = 4'd8;
    localparam logic [3:0] FMT_RATE_LAST    = 4'd11;
    localparam logic [3:0] FMT_INDEX_STOP   = 4'd12;

    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [23:0] TAG_FMT  = 24'h74_6D66;

    typedef struct packed {
        logic [31:0] fallback_rate;
        logic [7:0]  chunk_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_byte_item;

    typedef struct packed {
        logic        header_ok;
        logic [31:0] bytes_per_sec;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } t_result;

    typedef struct packed {
        logic [2:0] phase;
        logic       emit;
    } t_parse_status;

    function automatic logic [7:0] riff_magic_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h52;
            4'd1:    b = 8'h49;
            4'd2:    b = 8'h46;
            4'd3:    b = 8'h46;
            4'd8:    b = 8'h57;
            4'd9:    b = 8'h41;
            4'd10:   b = 8'h56;
            4'd11:   b = 8'h45;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wrp_cfg_regs.sv =====
// Configuration registers of the RIFF/WAVE header parser.
`default_nettype none

module wrp_cfg_regs
    import wrp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    output t_cfg                        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_FALLBACK_RATE: n_cfg.fallback_rate = i_cfg_wdata;
                CFG_IDX_CHUNK_LIMIT:   n_cfg.chunk_limit   = i_cfg_wdata[7:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fallback_rate <= FALLBACK_RATE_RESET;
            r_cfg.chunk_limit   <= CHUNK_LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/wrp_in_stage.sv =====
// Input register that holds one byte transaction for the parser.
`default_nettype none

module wrp_in_stage
    import wrp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_byte_item i_item,
    output logic            o_item_valid,
    output t_byte_item      o_item,
    input  wire logic       i_item_take
);

    logic       r_valid;
    logic       n_valid;
    t_byte_item r_item;
    logic       accept;

    assign o_in_stall = r_valid && !i_item_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_item_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

`default_nettype wire

// ===== rtl/wrp_parser.sv =====
// Parse state machine and result register of the RIFF/WAVE header parser.
`default_nettype none

module wrp_parser
    import wrp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_item_valid,
    input  wire t_byte_item i_item,
    output logic            o_item_take,
    input  wire logic       i_out_stall,
    output logic            o_out_valid,
    output t_result         o_result,
    output t_parse_status   o_status
);

    logic [2:0]  r_phase;
    logic [31:0] r_ofs;
    logic [3:0]  r_idx;
    logic [31:0] r_tag;
    logic [31:0] r_size;
    logic [31:0] r_skip;
    logic [7:0]  r_seen;
    logic [31:0] r_rate;
    logic        r_out_valid;
    t_result     r_result;

    logic [2:0]  n_phase;
    logic [31:0] n_ofs;
    logic [3:0]  n_idx;
    logic [31:0] n_tag;
    logic [31:0] n_size;
    logic [31:0] n_skip;
    logic [7:0]  n_seen;
    logic [31:0] n_rate;
    logic        n_out_valid;
    t_result     n_result;

    logic        out_free;
    logic        fire;
    logic        emit;
    logic        ok;
    logic        bad_magic;
    logic [31:0] byte_word;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = i_item_valid && out_free;
    assign o_item_take = fire;
    assign byte_word   = {24'd0, i_item.data_byte};

    always_comb begin
        n_phase   = r_phase;
        n_ofs     = r_ofs;
        n_idx     = r_idx;
        n_tag     = r_tag;
        n_size    = r_size;
        n_skip    = r_skip;
        n_seen    = r_seen;
        n_rate    = r_rate;
        emit      = 1'b0;
        ok        = 1'b0;
        bad_magic = 1'b0;
        n_result  = r_result;

        if (fire && (i_item.first_byte || r_phase != PH_DONE)) begin
            if (i_item.first_byte) begin
                n_phase = PH_RIFF;
                n_ofs   = '0;
                n_idx   = '0;
                n_tag   = '0;
                n_size  = '0;
                n_skip  = '0;
                n_seen  = '0;
                n_rate  = i_cfg.fallback_rate;
            end else begin
                n_ofs = r_ofs + 32'd1;
            end

            n_result.bytes_per_sec = n_rate;
            n_result.data_offset   = n_ofs + 32'd1;

            case (n_phase)
                PH_RIFF: begin
                    bad_magic = (n_idx >= MAGIC_LEN) ||
                        ((n_idx < MAGIC_SIZE_FIRST || n_idx >= MAGIC_WAVE_FIRST) &&
                         i_item.data_byte != riff_magic_byte(n_idx));
                    if (bad_magic) begin
                        emit = 1'b1;
                    end else if (n_idx == MAGIC_LAST) begin
                        if (i_cfg.chunk_limit == 8'd0) begin
                            emit = 1'b1;
                        end else begin
                            n_phase = PH_HDR;
                            n_idx   = '0;
                        end
                    end else begin
                        n_idx = n_idx + 4'd1;
                    end
                end
                PH_HDR: begin
                    if (n_idx < HDR_SIZE_FIRST) begin
                        n_tag = ((n_idx == 4'd0) ? 32'd0 : n_tag) |
                            (byte_word << {n_idx[1:0], 3'b000});
                    end else if (n_idx <= HDR_LAST) begin
                        n_size = ((n_idx == HDR_SIZE_FIRST) ? 32'd0 : n_size) |
                            (byte_word << {n_idx[1:0], 3'b000});
                    end
                    if (n_idx >= HDR_LAST) begin
                        if (n_tag == TAG_DATA) begin
                            emit = 1'b1;
                            ok   = 1'b1;
                            n_result.bytes_per_sec = (n_rate != 32'd0) ? n_rate
                                                                      : i_cfg.fallback_rate;
                            n_result.data_size = n_size;
                        end else begin
                            n_seen = n_seen + 8'd1;
                            if (n_seen >= i_cfg.chunk_limit) begin
                                emit = 1'b1;
                            end else begin
                                n_skip = n_size;
                                n_idx  = '0;
                                if (n_size == 32'd0) begin
                                    n_phase = PH_HDR;
                                end else if (n_tag[23:0] == TAG_FMT) begin
                                    n_phase = PH_FMT;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                    end else begin
                        n_idx = n_idx + 4'd1;
                    end
                end
                PH_FMT: begin
                    if (n_idx >= FMT_RATE_FIRST && n_idx <= FMT_RATE_LAST) begin
                        n_tag = {i_item.data_byte, n_tag[31:8]};
                        if (n_idx == FMT_RATE_LAST) begin
                            n_rate = n_tag;
                        end
                    end
                    if (n_idx < FMT_INDEX_STOP) begin
                        n_idx = n_idx + 4'd1;
                    end
                    n_skip = n_skip - 32'd1;
                    if (n_skip == 32'd0) begin
                        n_phase = PH_HDR;
                        n_idx   = '0;
                    end
                end
                PH_SKIP: begin
                    n_skip = n_skip - 32'd1;
                    if (n_skip == 32'd0) begin
                        n_phase = PH_HDR;
                        n_idx   = '0;
                    end
                end
                default: begin
                    emit = 1'b1;
                end
            endcase

            if (i_item.last_byte) begin
                emit = 1'b1;
            end

            if (emit) begin
                n_phase            = PH_DONE;
                n_result.header_ok = ok;
                if (!ok) begin
                    n_result.bytes_per_sec = '0;
                    n_result.data_offset   = '0;
                    n_result.data_size     = '0;
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ofs  <= n_ofs;
        r_idx  <= n_idx;
        r_tag  <= n_tag;
        r_size <= n_size;
        r_skip <= n_skip;
        r_seen <= n_seen;
        r_rate <= n_rate;
        if (emit) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result       = r_result;
    assign o_status.phase = r_phase;
    assign o_status.emit  = emit;

endmodule

`default_nettype wire

// ===== rtl/wav_riff_header_parser_top.sv =====
// An accepted byte is held in the input register until the parser takes it, and the
// result that it completes is registered in the result register and offered from there.
// Throughput: one byte transaction per cycle; the input register and the parse
// state advance every cycle unless a result waits in a stalled result register.
// Reset (synchronous, active low) empties both registers, returns the parser to
// the done state awaiting a first byte, and restores rate 32000 and limit 20.
`default_nettype none

`include "wav_riff_header_parser_top_defines.svh"

module wav_riff_header_parser_top
    import wrp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_first_byte,
    input  wire logic                   i_last_byte,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_header_ok,
    output logic [31:0]                 o_bytes_per_sec,
    output logic [31:0]                 o_data_offset,
    output logic [31:0]                 o_data_size,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_cfg          cfg;
    t_byte_item    in_item;
    t_byte_item    stage_item;
    logic          stage_valid;
    logic          stage_take;
    t_result       result;
    t_parse_status status;

    assign in_item.data_byte  = i_data_byte;
    assign in_item.first_byte = i_first_byte;
    assign in_item.last_byte  = i_last_byte;

    wrp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    wrp_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_item       (in_item),
        .o_item_valid (stage_valid),
        .o_item       (stage_item),
        .i_item_take  (stage_take)
    );

    wrp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (stage_valid),
        .i_item       (stage_item),
        .o_item_take  (stage_take),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_result     (result),
        .o_status     (status)
    );

    assign o_header_ok     = result.header_ok;
    assign o_bytes_per_sec = result.bytes_per_sec;
    assign o_data_offset   = result.data_offset;
    assign o_data_size     = result.data_size;

    `WRP_ASSERT_NOW(a_fail_fields_zero, i_clk, i_rst_n, o_out_valid && !o_header_ok, o_bytes_per_sec == 32'd0 && o_data_offset == 32'd0 && o_data_size == 32'd0)
    `WRP_ASSERT_NEXT(a_emit_ends_parse, i_clk, i_rst_n, status.emit, status.phase == PH_DONE && o_out_valid)
    `WRP_ASSERT_NOW(a_stall_only_on_full_out, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall && stage_valid)

endmodule

`default_nettype wire
